>>> rtl/hsp_pkg.sv
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and constants of the 3d heat stencil pass
// geometry widths, register codes, divide-by-seven constants
// ----------------------------------------------------------------------------
package hsp_pkg;

  localparam int MAX_EDGE   = 64;
  localparam int TEMP_BITS  = 16;
  localparam int HIST_DEPTH = 2 * MAX_EDGE * MAX_EDGE;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SPAN_W     = $clog2(HIST_DEPTH + 1);
  localparam int PLANE_W    = $clog2(MAX_EDGE * MAX_EDGE + 1);
  localparam int COUNT_W    = $clog2(MAX_EDGE * MAX_EDGE * MAX_EDGE + 1);
  localparam int EDGE_W     = 7;
  localparam int COORD_W    = 6;

  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;

  localparam logic [EDGE_W-1:0]  EDGE_RESET   = EDGE_W'(50);
  localparam logic [COORD_W-1:0] SOURCE_RESET = COORD_W'(12);
  localparam logic [EDGE_W-1:0]  EDGE_MAX     = EDGE_W'(MAX_EDGE);
  localparam logic [1:0]         SETTLE_CYCLES = 2'd3;

  // round-to-nearest divide by seven as (sum + 3) * m >> shift
  localparam int SUM_W      = TEMP_BITS + 3;
  localparam int DIV_SHIFT  = SUM_W + 3;
  localparam int DIV_MUL_W  = DIV_SHIFT - 2;
  localparam int DIV_MUL    = (2 ** DIV_SHIFT + 6) / 7;
  localparam int PROD_W     = SUM_W + DIV_MUL_W;

  typedef enum logic [1:0] {
    REG_EDGE_LENGTH = 2'd0,
    REG_SOURCE_I    = 2'd1,
    REG_SOURCE_J    = 2'd2,
    REG_SOURCE_K    = 2'd3
  } reg_idx_t;

  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct packed {
    logic                ready;
    logic [EDGE_W-1:0]   edge_len;
    logic [COORD_W-1:0]  edge_m1;
    logic [PLANE_W-1:0]  plane;
    logic [SPAN_W-1:0]   span;
    logic [COUNT_W-1:0]  total;
    logic [COORD_W-1:0]  src_i;
    logic [COORD_W-1:0]  src_j;
    logic [COORD_W-1:0]  src_k;
  } geom_t;

endpackage

>>> rtl/hsp_ram.sv
// ----------------------------------------------------------------------------
// hsp_ram: generic simple ram
// one write port, two read ports, registered read data, read-before-write
// ----------------------------------------------------------------------------
module hsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> rtl/hsp_cfg.sv
// ----------------------------------------------------------------------------
// hsp_cfg: configuration registers and derived cube geometry
// apb register file, edge clamp, plane / span / total cell counts
// ----------------------------------------------------------------------------
module hsp_cfg
  import hsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output geom_t             geom
);

  logic [EDGE_W-1:0]    edge_length;
  logic [COORD_W-1:0]   source_i;
  logic [COORD_W-1:0]   source_j;
  logic [COORD_W-1:0]   source_k;
  logic [1:0]           settle;
  logic [EDGE_W-1:0]    edge_eff;
  logic [PLANE_W-1:0]   plane;
  logic [COUNT_W-1:0]   total;
  logic [2*EDGE_W-1:0]  square;
  logic [PLANE_W+EDGE_W-1:0] cube;
  logic                 wr_en;
  reg_idx_t             wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_length <= EDGE_RESET;
      source_i    <= SOURCE_RESET;
      source_j    <= SOURCE_RESET;
      source_k    <= SOURCE_RESET;
      settle      <= SETTLE_CYCLES;
    end else begin
      if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
      if (wr_en) begin
        unique case (wr_idx)
          REG_EDGE_LENGTH: begin
            edge_length <= pwdata[EDGE_W-1:0];
            settle      <= SETTLE_CYCLES;
          end
          REG_SOURCE_I: source_i <= pwdata[COORD_W-1:0];
          REG_SOURCE_J: source_j <= pwdata[COORD_W-1:0];
          REG_SOURCE_K: source_k <= pwdata[COORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_EDGE_LENGTH: prdata = APB_DW'(edge_length);
      REG_SOURCE_I:    prdata = APB_DW'(source_i);
      REG_SOURCE_J:    prdata = APB_DW'(source_j);
      REG_SOURCE_K:    prdata = APB_DW'(source_k);
      default:         prdata = '0;
    endcase
  end

  // geometry follows the edge register through three register stages
  assign square = edge_eff * edge_eff;
  assign cube   = plane * edge_eff;

  always_ff @(posedge clk) begin
    if (edge_length == '0) begin
      edge_eff <= EDGE_W'(1);
    end else if (edge_length > EDGE_MAX) begin
      edge_eff <= EDGE_MAX;
    end else begin
      edge_eff <= edge_length;
    end
    plane <= square[PLANE_W-1:0];
    total <= cube[COUNT_W-1:0];
  end

  always_comb begin
    geom.ready    = (settle == 2'd0);
    geom.edge_len = edge_eff;
    geom.edge_m1  = COORD_W'(edge_eff - EDGE_W'(1));
    geom.plane    = plane;
    geom.span     = {plane, 1'b0};
    geom.total    = total;
    geom.src_i    = source_i;
    geom.src_j    = source_j;
    geom.src_k    = source_k;
  end

endmodule

>>> rtl/heat_stencil_3d_pass_core.sv
// ----------------------------------------------------------------------------
// heat_stencil_3d_pass_core: one jacobi time step of a 7-point 3d heat stencil
// a result passes stage 1, stage 2 and the output queue after the transfer that completes it
// throughput: one item per cycle while s_tready is high, set by two history rams with two reads each
// results wait in a 4-entry output queue; input stalls once four results are queued or in flight
// reset: pass counters clear, history ram is not cleared; no transfer is taken after reset
// or after an edge_length write while the geometry settles
// ----------------------------------------------------------------------------
module heat_stencil_3d_pass_core
  import hsp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // apb configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TEMP_BITS-1:0] s_tdata,   // [15:0] cell_temp
  input  logic                 s_tuser,   // [0] mode
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [TEMP_BITS-1:0] m_tdata,   // [15:0] new_temp
  output logic                 m_tlast
);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int OUT_W      = TEMP_BITS + 1;

  geom_t g;

  hsp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geom    (g)
  );

  // ---------------- pass state ----------------
  logic [COUNT_W-1:0] rec, emi;
  logic [COORD_W-1:0] ci, cj, ck;
  logic [HIST_AW-1:0] rd_slot, wr_slot;

  logic               restart;
  logic [COUNT_W-1:0] rec0, emi0, after, need_raw, need, emi_next, rec_next;
  logic [COORD_W-1:0] ci0, cj0, ck0, ci_next, cj_next, ck_next;
  logic [HIST_AW-1:0] rd0, wr0, rd_next, wr_next;
  logic               s_fire, have_in, emit, pass_done, last0, src0;
  logic [SPAN_W-1:0]  rd_w, wr_inc, rd_inc, south_w, pl_w, e_w;
  logic [HIST_AW-1:0] addr_up, addr_north, addr_east, addr_south;

  logic [FIFO_CW-1:0] fcount;
  logic               v1, v2;

  assign s_tready = g.ready && ((fcount + FIFO_CW'(v1) + FIFO_CW'(v2)) < FIFO_CW'(FIFO_DEPTH));
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    // counters that no longer fit the cube start over
    restart = (rec > g.total) || (emi >= g.total) || (emi > rec);
    rec0 = restart ? '0 : rec;
    emi0 = restart ? '0 : emi;
    ci0  = restart ? '0 : ci;
    cj0  = restart ? '0 : cj;
    ck0  = restart ? '0 : ck;
    rd0  = restart ? '0 : rd_slot;
    wr0  = restart ? '0 : wr_slot;

    have_in  = s_fire && (s_tuser == MODE_CELL) && (rec0 < g.total);
    after    = rec0 + COUNT_W'(have_in);
    need_raw = emi0 + COUNT_W'(g.plane) + COUNT_W'(1);
    need     = (need_raw > g.total) ? g.total : need_raw;
    emit     = s_fire && (after >= need);
    last0    = (emi0 == g.total - COUNT_W'(1));
    src0     = (ci0 == g.src_i) && (cj0 == g.src_j) && (ck0 == g.src_k);

    // neighbour slots in the circular two-plane history
    rd_w = SPAN_W'(rd0);
    pl_w = SPAN_W'(g.plane);
    e_w  = SPAN_W'(g.edge_len);
    if (ci0 == '0) begin
      addr_up = rd0;  // no upper plane: this port fetches the centre instead
    end else if (rd_w >= pl_w) begin
      addr_up = HIST_AW'(rd_w - pl_w);
    end else begin
      addr_up = HIST_AW'(rd_w + pl_w);
    end
    if (rd_w >= e_w) begin
      addr_north = HIST_AW'(rd_w - e_w);
    end else begin
      addr_north = HIST_AW'(rd_w + g.span - e_w);
    end
    rd_inc    = rd_w + SPAN_W'(1);
    addr_east = (rd_inc == g.span) ? '0 : HIST_AW'(rd_inc);
    south_w   = rd_w + e_w;
    addr_south = (south_w >= g.span) ? HIST_AW'(south_w - g.span) : HIST_AW'(south_w);

    wr_inc  = SPAN_W'(wr0) + SPAN_W'(1);
    wr_next = have_in ? ((wr_inc == g.span) ? '0 : HIST_AW'(wr_inc)) : wr0;
    rd_next = emit ? addr_east : rd0;

    ci_next = ci0;
    cj_next = cj0;
    ck_next = ck0;
    if (emit) begin
      if (ck0 == g.edge_m1) begin
        ck_next = '0;
        if (cj0 == g.edge_m1) begin
          cj_next = '0;
          ci_next = ci0 + COORD_W'(1);
        end else begin
          cj_next = cj0 + COORD_W'(1);
        end
      end else begin
        ck_next = ck0 + COORD_W'(1);
      end
    end

    rec_next  = after;
    emi_next  = emi0 + COUNT_W'(emit);
    pass_done = (emi_next >= g.total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec     <= '0;
      emi     <= '0;
      ci      <= '0;
      cj      <= '0;
      ck      <= '0;
      rd_slot <= '0;
      wr_slot <= '0;
    end else if (s_fire) begin
      if (pass_done) begin
        rec     <= '0;
        emi     <= '0;
        ci      <= '0;
        cj      <= '0;
        ck      <= '0;
        rd_slot <= '0;
        wr_slot <= '0;
      end else begin
        rec     <= rec_next;
        emi     <= emi_next;
        ci      <= ci_next;
        cj      <= cj_next;
        ck      <= ck_next;
        rd_slot <= rd_next;
        wr_slot <= wr_next;
      end
    end
  end

  // ---------------- history rams ----------------
  // both hold the same history; the write of cell n+plane lands on the slot
  // of cell n-plane in the same cycle, and read-before-write returns the old cell
  logic [TEMP_BITS-1:0] ra0, ra1, rb0, rb1;

  hsp_ram #(.WIDTH(TEMP_BITS), .DEPTH(HIST_DEPTH)) u_ram_a (
    .clk    (clk),
    .we     (have_in),
    .waddr  (wr0),
    .wdata  (s_tdata),
    .raddr0 (addr_up),
    .raddr1 (addr_north),
    .rdata0 (ra0),
    .rdata1 (ra1)
  );

  hsp_ram #(.WIDTH(TEMP_BITS), .DEPTH(HIST_DEPTH)) u_ram_b (
    .clk    (clk),
    .we     (have_in),
    .waddr  (wr0),
    .wdata  (s_tdata),
    .raddr0 (addr_east),
    .raddr1 (addr_south),
    .rdata0 (rb0),
    .rdata1 (rb1)
  );

  // ---------------- stage 1: gather and sum ----------------
  logic                 last1, src1, one1;
  logic                 i0_1, ie_1, j0_1, je_1, k0_1, ke_1;
  logic [TEMP_BITS-1:0] din1, c_reg, cprev;
  logic [TEMP_BITS-1:0] c1, up1, down1, north1, south1, west1, east1;
  logic [SUM_W-1:0]     sum1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= emit;
    end
    last1 <= last0;
    src1  <= src0;
    one1  <= (g.edge_len == EDGE_W'(1));
    i0_1  <= (ci0 == '0);
    ie_1  <= (ci0 == g.edge_m1);
    j0_1  <= (cj0 == '0);
    je_1  <= (cj0 == g.edge_m1);
    k0_1  <= (ck0 == '0);
    ke_1  <= (ck0 == g.edge_m1);
    din1  <= s_tdata;
  end

  always_comb begin
    // centre: the input itself on a single-cell cube, the ram on the first
    // plane, else the east read kept from the previous cell
    if (one1) begin
      c1 = din1;
    end else if (i0_1) begin
      c1 = ra0;
    end else begin
      c1 = c_reg;
    end
    up1    = i0_1 ? c1 : ra0;
    down1  = ie_1 ? c1 : din1;
    north1 = j0_1 ? c1 : ra1;
    south1 = je_1 ? c1 : rb1;
    west1  = k0_1 ? c1 : cprev;
    east1  = ke_1 ? c1 : rb0;
    sum1 = SUM_W'(c1) + SUM_W'(up1) + SUM_W'(down1) + SUM_W'(north1)
         + SUM_W'(south1) + SUM_W'(west1) + SUM_W'(east1);
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      c_reg <= rb0;
      cprev <= c1;
    end
  end

  // ---------------- stage 2: divide by seven ----------------
  logic                 last2, src2;
  logic [TEMP_BITS-1:0] c2, res2;
  logic [SUM_W-1:0]     sum2;
  logic [PROD_W-1:0]    prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    last2 <= last1;
    src2  <= src1;
    c2    <= c1;
    sum2  <= sum1;
  end

  always_comb begin
    prod2 = PROD_W'(sum2 + SUM_W'(3)) * PROD_W'(DIV_MUL);
    res2  = src2 ? c2 : prod2[DIV_SHIFT +: TEMP_BITS];
  end

  // ---------------- output queue ----------------
  logic [OUT_W-1:0]   fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] fifo_wr, fifo_rd;
  logic               push, pop;

  assign push     = v2;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (fcount != '0);
  assign m_tdata  = fifo_mem[fifo_rd][TEMP_BITS-1:0];
  assign m_tlast  = fifo_mem[fifo_rd][TEMP_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount  <= '0;
      fifo_wr <= '0;
      fifo_rd <= '0;
    end else begin
      fcount <= fcount + FIFO_CW'(push) - FIFO_CW'(pop);
      if (push) begin
        fifo_wr <= fifo_wr + FIFO_AW'(1);
      end
      if (pop) begin
        fifo_rd <= fifo_rd + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[fifo_wr] <= {last2, res2};
    end
  end

  // ---------------- assertions ----------------
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> ((fcount < FIFO_CW'(FIFO_DEPTH)) || pop))
    else $error("output queue overflow");

  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    emi <= rec)
    else $error("more cells emitted than received");

  a_pass_wrap: assert property (@(posedge clk) disable iff (rst)
    (emit && last0) |=> ((rec == '0) && (emi == '0)))
    else $error("pass counters did not wrap after the last cell");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for heat_stencil_3d_pass_core
// streams cube passes of random Q10.6 temperatures with flushes and noise,
// predicts every updated cell in a scoreboard, and compares each output transfer
// ----------------------------------------------------------------------------
module tb
  import hsp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 36;
  localparam int HOLD_CYCLES = 250;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam int RANDOM_ITEMS = 220;

  typedef struct {
    logic                 mode;
    logic [TEMP_BITS-1:0] temp;
  } feed_item_t;

  typedef struct {
    logic [TEMP_BITS-1:0] temp;
    logic                 last;
  } stencil_out_t;

  // tracks pass counters, plane history and geometry; predicts each updated cell
  class heat_step_tracker;
    logic [TEMP_BITS-1:0] plane_mem [HIST_DEPTH];
    int unsigned          received;
    int unsigned          emitted;
    logic [EDGE_W-1:0]    edge_reg;
    logic [COORD_W-1:0]   src_i, src_j, src_k;
    stencil_out_t         due_cells[$];
    int                   faults;

    function void clear();
      received  = 0;
      emitted   = 0;
      edge_reg  = EDGE_RESET;
      src_i     = SOURCE_RESET;
      src_j     = SOURCE_RESET;
      src_k     = SOURCE_RESET;
      faults    = 0;
      due_cells.delete();
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_EDGE_LENGTH: edge_reg = value[EDGE_W-1:0];
        REG_SOURCE_I:    src_i = value[COORD_W-1:0];
        REG_SOURCE_J:    src_j = value[COORD_W-1:0];
        REG_SOURCE_K:    src_k = value[COORD_W-1:0];
        default: ;
      endcase
    endfunction

    // the arriving cell is used straight from the input, the rest from history
    function int unsigned neighbour(int unsigned idx, int unsigned span, bit have_in,
                                    int unsigned in_idx, logic [TEMP_BITS-1:0] in_val);
      if (have_in && idx == in_idx)
        return in_val;
      return plane_mem[idx % span];
    endfunction

    function void take_item(logic mode, logic [TEMP_BITS-1:0] temp);
      int unsigned e_sz, plane, total, span, in_idx, after, need;
      int unsigned n, ci, cj, ck, c, sum;
      bit          have_in;
      stencil_out_t res;
      if (edge_reg == 0)
        e_sz = 1;
      else if (edge_reg > MAX_EDGE)
        e_sz = MAX_EDGE;
      else
        e_sz = edge_reg;
      plane = e_sz * e_sz;
      total = plane * e_sz;
      span  = 2 * plane;
      if (received > total || emitted >= total || emitted > received) begin
        received = 0;
        emitted  = 0;
      end
      have_in = (mode == MODE_CELL) && (received < total);
      in_idx  = received;
      after   = received + (have_in ? 1 : 0);
      need    = emitted + plane + 1;
      if (need > total)
        need = total;
      if (after >= need) begin
        n  = emitted;
        ck = n % e_sz;
        cj = (n / e_sz) % e_sz;
        ci = n / plane;
        c  = neighbour(n, span, have_in, in_idx, temp);
        if (ci == src_i && cj == src_j && ck == src_k) begin
          res.temp = c[TEMP_BITS-1:0];
        end else begin
          // out-of-cube neighbours take the centre value
          sum = c;
          if (ci == 0) sum += c;
          else sum += neighbour(n - plane, span, have_in, in_idx, temp);
          if (ci == e_sz - 1) sum += c;
          else sum += neighbour(n + plane, span, have_in, in_idx, temp);
          if (cj == 0) sum += c;
          else sum += neighbour(n - e_sz, span, have_in, in_idx, temp);
          if (cj == e_sz - 1) sum += c;
          else sum += neighbour(n + e_sz, span, have_in, in_idx, temp);
          if (ck == 0) sum += c;
          else sum += neighbour(n - 1, span, have_in, in_idx, temp);
          if (ck == e_sz - 1) sum += c;
          else sum += neighbour(n + 1, span, have_in, in_idx, temp);
          sum = (sum + 3) / 7;
          res.temp = sum[TEMP_BITS-1:0];
        end
        res.last = (n == total - 1);
        due_cells.push_back(res);
        emitted = n + 1;
      end
      if (have_in)
        plane_mem[in_idx % span] = temp;
      received = after;
      if (emitted >= total) begin
        received = 0;
        emitted  = 0;
      end
    endfunction

    function void check_out(logic [TEMP_BITS-1:0] temp, logic last);
      stencil_out_t want;
      if (due_cells.size() == 0) begin
        $error("new_temp: expected no transfer, got %0d", temp);
        faults++;
        return;
      end
      want = due_cells.pop_front();
      if (temp !== want.temp) begin
        $error("new_temp: expected %0d, got %0d", want.temp, temp);
        faults++;
      end
      if (last !== want.last) begin
        $error("last_cell: expected %0b, got %0b", want.last, last);
        faults++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [APB_AW-1:0]    paddr    = '0;
  logic [APB_DW-1:0]    pwdata   = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [TEMP_BITS-1:0] s_tdata  = '0;   // [15:0] cell_temp
  logic                 s_tuser  = 1'b0; // [0] mode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TEMP_BITS-1:0] m_tdata;         // [15:0] new_temp
  logic                 m_tlast;

  heat_step_tracker tracker;
  feed_item_t       feed_q[$];
  int               items_fed    = 0;
  int               items_taken  = 0;
  int               random_items = 0;
  int               hold_asks    = 0;
  bit               steady       = 1'b0;

  heat_stencil_3d_pass_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender: offers queued items, idling at random unless in a steady stretch
  always @(posedge clk) begin : sender
    feed_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tracker.take_item(s_tuser, s_tdata);
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (feed_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.mode;
          s_tdata  <= nxt.temp;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure plus a long hold-off on request
  always @(posedge clk) begin : receiver
    int hold_seen;
    int hold_cnt;
    if (m_tvalid && m_tready && !rst)
      tracker.check_out(m_tdata, m_tlast);
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("heat_stencil_3d_pass_core: mismatch");
      $finish;
    end
  end

  function automatic logic [TEMP_BITS-1:0] rand_temp();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return '0;
    if (pick == 1)
      return '1;
    return TEMP_BITS'($urandom_range(0, 65535));
  endfunction

  task automatic add_item(logic mode, logic [TEMP_BITS-1:0] temp);
    feed_item_t it;
    it.mode = mode;
    it.temp = temp;
    feed_q.push_back(it);
    items_fed++;
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, value);
  endtask

  task automatic set_geometry(int edge_len, int si, int sj, int sk);
    apb_write(REG_EDGE_LENGTH, edge_len);
    apb_write(REG_SOURCE_I, si);
    apb_write(REG_SOURCE_J, sj);
    apb_write(REG_SOURCE_K, sk);
  endtask

  // wait for every item taken and every result seen, then let the pipeline empty
  task automatic settle();
    do @(negedge clk);
    while (items_taken != items_fed || tracker.due_cells.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // one full pass with noise flushes, then a drain mixing flushes and dead cells
  task automatic queue_pass(int e_sz);
    int plane;
    int total;
    int drain;
    plane = e_sz * e_sz;
    total = plane * e_sz;
    drain = (e_sz == 1) ? 0 : plane;
    for (int n = 0; n < total; n++) begin
      if ($urandom_range(99) < 8)
        add_item(MODE_FLUSH, rand_temp());
      add_item(MODE_CELL, rand_temp());
      random_items++;
    end
    for (int d = 0; d < drain; d++) begin
      if ($urandom_range(99) < 25)
        add_item(MODE_CELL, rand_temp());
      else
        add_item(MODE_FLUSH, rand_temp());
      random_items++;
    end
    if ($urandom_range(99) < 30)
      add_item(MODE_FLUSH, rand_temp());
  endtask

  initial begin : main
    int  e_sz;
    int  si, sj, sk;
    bit  first;
    bit  big_done;
    tracker = new;
    tracker.clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // edge length zero acts as a single-cell cube, source at the origin
    set_geometry(0, 0, 0, 0);
    add_item(MODE_FLUSH, 16'h0000);
    add_item(MODE_CELL, 16'hFFFF);
    add_item(MODE_CELL, 16'h0000);
    add_item(MODE_CELL, 16'h1234);
    add_item(MODE_FLUSH, 16'hFFFF);
    settle();

    // single cell, source outside the cube
    set_geometry(1, 5, 63, 0);
    add_item(MODE_CELL, 16'hFFFF);
    add_item(MODE_CELL, 16'h0001);
    add_item(MODE_CELL, 16'h8000);
    settle();

    // 2x2x2 pass, then cells after completion, flush drain, flush with nothing ready
    set_geometry(2, 1, 0, 1);
    add_item(MODE_CELL, 16'hFFFF);
    add_item(MODE_CELL, 16'h0000);
    add_item(MODE_CELL, 16'hFFFF);
    add_item(MODE_CELL, 16'h0000);
    add_item(MODE_CELL, 16'hAAAA);
    add_item(MODE_CELL, 16'h5555);
    add_item(MODE_CELL, 16'hFFFF);
    add_item(MODE_CELL, 16'h0001);
    add_item(MODE_CELL, 16'h7777);
    add_item(MODE_CELL, 16'hFFFF);
    add_item(MODE_FLUSH, 16'h0000);
    add_item(MODE_FLUSH, 16'hFFFF);
    add_item(MODE_FLUSH, 16'h0000);
    settle();

    first    = 1'b1;
    big_done = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      e_sz = first ? 4 : $urandom_range(1, 5);
      if ($urandom_range(1) == 1) begin
        si = $urandom_range(0, e_sz - 1);
        sj = $urandom_range(0, e_sz - 1);
        sk = $urandom_range(0, e_sz - 1);
      end else begin
        si = $urandom_range(0, 63);
        sj = $urandom_range(0, 63);
        sk = $urandom_range(0, 63);
      end
      set_geometry(e_sz, si, sj, sk);
      if (first)
        hold_asks++;
      queue_pass(e_sz);
      settle();
      first = 1'b0;

      // oversized edge saturates to the maximum; two rows, no idling.
      // the next smaller cube restarts the abandoned pass
      if (!big_done && random_items >= 150) begin
        steady = 1'b1;
        set_geometry(127, 0, 0, 63);
        for (int n = 0; n < 2 * MAX_EDGE; n++)
          add_item(MODE_CELL, rand_temp());
        settle();
        steady   = 1'b0;
        big_done = 1'b1;
      end
    end

    settle();
    if (tracker.faults == 0)
      $display("heat_stencil_3d_pass_core: match");
    else
      $display("heat_stencil_3d_pass_core: mismatch");
    $finish;
  end

endmodule

>>> files.f
rtl/hsp_pkg.sv
rtl/hsp_ram.sv
rtl/hsp_cfg.sv
rtl/heat_stencil_3d_pass_core.sv
tb/tb.sv
